FILE: hw/rtl/rhpm_pkg.sv
// Shared types, constants and helpers of the rolling hash pattern matcher.
package rhpm_pkg;

    localparam int RHPM_MAX_PATTERN = 16;
    localparam int RHPM_INDEX_WIDTH = 32;

    localparam int HASH_W      = 31;
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 4;
    localparam int MATCH_IDX_W = 32;
    localparam int PAT_SEL_W   = 6;

    localparam logic [HASH_W-1:0] MODULUS_RESET = 31'd998244353;
    localparam logic [HASH_W-1:0] MODULUS_MIN   = 31'd2;
    localparam logic [LEN_W-1:0]  LENGTH_RESET  = 5'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 4'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } in_item_t;

    typedef struct packed {
        logic                   match_found;
        logic [MATCH_IDX_W-1:0] match_index;
        logic                   text_done;
    } out_item_t;

    typedef enum logic [1:0] {
        MOP_SHIFT,
        MOP_ADD,
        MOP_NEG
    } mod_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_TGT,
        ST_PWR,
        ST_RED_H,
        ST_RED_T,
        ST_RED_P,
        ST_DBL,
        ST_ADD,
        ST_NEG,
        ST_SUB,
        ST_SHIFT,
        ST_CHECK,
        ST_CMP,
        ST_DONE
    } rhpm_state_t;

    // Pattern byte k of the two configured words; bytes past the sixteenth read as zero.
    function automatic logic [7:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                                input logic [CFG_DATA_W-1:0] hi,
                                                input logic [PAT_SEL_W-1:0]  k);
        logic [7:0] b;
        b = 8'd0;
        if (k[5:4] == 2'b00) begin
            if (!k[3]) begin
                b = lo[{k[2:0], 3'b000} +: 8];
            end else begin
                b = hi[{k[2:0], 3'b000} +: 8];
            end
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/rolling_hash_pattern_matcher.sv
// Each byte runs through the shared modular unit, which does one step a cycle: first the outgoing
// byte once the window is full, then the incoming one, then up to len byte compares.
// The first byte of each text first hashes the pattern and the leading power.
// A changed modulus within a text first reduces the three stored hash values.
// One byte is worked on at a time; the result register frees the input side.
// Reset: synchronous, active low; config returns to defaults and the next byte starts a text.
module rolling_hash_pattern_matcher
    import rhpm_pkg::*;
#(
    parameter int MAX_PATTERN = RHPM_MAX_PATTERN,
    parameter int INDEX_WIDTH = RHPM_INDEX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration registers.
    logic [HASH_W-1:0]     hash_modulus_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [CFG_DATA_W-1:0] pattern_word_low_reg;
    logic [CFG_DATA_W-1:0] pattern_word_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_modulus_reg      <= MODULUS_RESET;
            pattern_length_reg    <= LENGTH_RESET;
            pattern_word_low_reg  <= '0;
            pattern_word_high_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_HASH_MODULUS:   hash_modulus_reg      <= cfg_data[HASH_W-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg    <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    pattern_word_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_word_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective modulus and length.
    logic [HASH_W-1:0] p_eff;
    logic [5:0]        len_wide;
    logic [5:0]        len_clamp;
    logic [CNT_W-1:0]  len_eff;
    logic [CNT_W-1:0]  len_m1;

    assign p_eff    = (hash_modulus_reg < MODULUS_MIN) ? MODULUS_MIN : hash_modulus_reg;
    assign len_wide = {1'b0, pattern_length_reg};

    always_comb begin
        len_clamp = len_wide;
        if (len_wide == 6'd0) begin
            len_clamp = 6'd1;
        end else if (len_wide > 6'(MAX_PATTERN)) begin
            len_clamp = 6'(MAX_PATTERN);
        end
    end

    assign len_eff = len_clamp[CNT_W-1:0];
    assign len_m1  = len_eff - CNT_W'(1);

    // State and datapath registers.
    rhpm_state_t            state_reg, state_next;
    logic                   setup_valid_reg, setup_valid_next;
    logic [INDEX_WIDTH-1:0] bytes_seen_reg, bytes_seen_next;
    logic [HASH_W-1:0]      window_hash_reg, window_hash_next;
    logic [HASH_W-1:0]      target_hash_reg, target_hash_next;
    logic [HASH_W-1:0]      leading_power_reg, leading_power_next;
    logic [HASH_W-1:0]      tgt_red_reg, tgt_red_next;
    logic [HASH_W-1:0]      pw_red_reg, pw_red_next;
    logic [HASH_W-1:0]      p_cache_reg, p_cache_next;
    logic [HASH_W-1:0]      acc_reg, acc_next;
    logic [4:0]             bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       byte_cnt_reg, byte_cnt_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic                   found_reg, found_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    // Shared unit and window connections.
    mod_op_t           mu_op;
    logic              mu_bit;
    logic [HASH_W-1:0] mu_addend;
    logic [HASH_W-1:0] mu_result;
    logic              win_shift;
    logic [CNT_W-1:0]  rd_pos;
    logic [7:0]        rd_byte;
    logic [7:0]        pat_byte;

    rhpm_mod_unit u_mod_unit (
        .op        (mu_op),
        .acc       (acc_reg),
        .shift_bit (mu_bit),
        .addend    (mu_addend),
        .modulus   (p_eff),
        .result    (mu_result)
    );

    rhpm_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk       (aclk),
        .shift_en   (win_shift),
        .shift_byte (byte_reg),
        .rd_idx     (rd_pos[IDX_W-1:0]),
        .rd_byte    (rd_byte)
    );

    assign pat_byte = pattern_byte(pattern_word_low_reg, pattern_word_high_reg,
                                   PAT_SEL_W'(byte_cnt_reg));

    // The compare walks the window from its oldest byte while the pattern index climbs.
    assign rd_pos = (state_reg == ST_CMP) ? (len_m1 - byte_cnt_reg) : len_m1;

    // Conditions used by the two combinational blocks.
    logic                   bytes_ge_len;
    logic                   bit_last;
    logic                   byte_last;
    logic                   out_free;
    logic                   hash_hit;
    logic [INDEX_WIDTH-1:0] start_pos;
    logic [MATCH_IDX_W-1:0] start_idx;

    assign bytes_ge_len = bytes_seen_reg >= INDEX_WIDTH'(len_eff);
    assign bit_last     = bit_cnt_reg == 5'd0;
    assign byte_last    = byte_cnt_reg == len_m1;
    assign out_free     = !m_valid_reg || m_ready;
    assign hash_hit     = bytes_ge_len && (window_hash_reg == tgt_red_reg);
    assign start_pos    = bytes_seen_reg - INDEX_WIDTH'(len_eff);

    generate
        if (INDEX_WIDTH >= MATCH_IDX_W) begin : g_idx_trunc
            assign start_idx = start_pos[MATCH_IDX_W-1:0];
        end else begin : g_idx_ext
            assign start_idx = {{(MATCH_IDX_W-INDEX_WIDTH){1'b0}}, start_pos};
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (!setup_valid_reg) begin
                    state_next = ST_TGT;
                end else if (p_eff != p_cache_reg) begin
                    state_next = ST_RED_H;
                end else if (bytes_ge_len) begin
                    state_next = ST_DBL;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_TGT: begin
                if (bit_last && byte_last) begin
                    state_next = (len_eff == CNT_W'(1)) ? ST_START : ST_PWR;
                end
            end
            ST_PWR: begin
                if (bit_last && ((byte_cnt_reg + CNT_W'(1)) == len_m1)) begin
                    state_next = ST_START;
                end
            end
            ST_RED_H: begin
                if (bit_last) begin
                    state_next = ST_RED_T;
                end
            end
            ST_RED_T: begin
                if (bit_last) begin
                    state_next = ST_RED_P;
                end
            end
            ST_RED_P: begin
                if (bit_last) begin
                    state_next = ST_START;
                end
            end
            ST_DBL: begin
                if (rd_byte[bit_cnt_reg[2:0]]) begin
                    state_next = ST_ADD;
                end else if (bit_last) begin
                    state_next = ST_NEG;
                end
            end
            ST_ADD: begin
                state_next = bit_last ? ST_NEG : ST_DBL;
            end
            ST_NEG: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (bit_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = hash_hit ? ST_CMP : ST_DONE;
            end
            ST_CMP: begin
                if ((rd_byte != pat_byte) || byte_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, unit control and outputs.
    always_comb begin
        setup_valid_next   = setup_valid_reg;
        bytes_seen_next    = bytes_seen_reg;
        window_hash_next   = window_hash_reg;
        target_hash_next   = target_hash_reg;
        leading_power_next = leading_power_reg;
        tgt_red_next       = tgt_red_reg;
        pw_red_next        = pw_red_reg;
        p_cache_next       = p_cache_reg;
        acc_next           = acc_reg;
        bit_cnt_next       = bit_cnt_reg;
        byte_cnt_next      = byte_cnt_reg;
        byte_next          = byte_reg;
        last_next          = last_reg;
        found_next         = found_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;
        mu_op              = MOP_SHIFT;
        mu_bit             = 1'b0;
        mu_addend          = pw_red_reg;
        win_shift          = 1'b0;
        s_ready            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // No beat is taken while reset is held.
                s_ready = aresetn;
                if (s_valid) begin
                    byte_next = s_data.text_byte;
                    last_next = s_data.text_last;
                end
            end
            ST_START: begin
                bit_cnt_next = 5'd7;
                if (!setup_valid_reg) begin
                    acc_next      = '0;
                    byte_cnt_next = '0;
                end else if (p_eff != p_cache_reg) begin
                    acc_next     = '0;
                    bit_cnt_next = 5'(HASH_W - 1);
                end else if (bytes_ge_len) begin
                    acc_next = '0;
                end else begin
                    acc_next = window_hash_reg;
                end
            end
            ST_TGT: begin
                // Horner step of the pattern hash, fed one pattern bit a cycle.
                mu_bit   = pat_byte[bit_cnt_reg[2:0]];
                acc_next = mu_result;
                if (bit_last) begin
                    bit_cnt_next  = 5'd7;
                    byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                    if (byte_last) begin
                        target_hash_next = mu_result;
                        tgt_red_next     = mu_result;
                        acc_next         = HASH_W'(1);
                        byte_cnt_next    = '0;
                        if (len_eff == CNT_W'(1)) begin
                            leading_power_next = HASH_W'(1);
                            pw_red_next        = HASH_W'(1);
                            setup_valid_next   = 1'b1;
                            window_hash_next   = '0;
                            bytes_seen_next    = '0;
                            p_cache_next       = p_eff;
                        end
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_PWR: begin
                acc_next = mu_result;
                if (bit_last) begin
                    bit_cnt_next  = 5'd7;
                    byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                    if ((byte_cnt_reg + CNT_W'(1)) == len_m1) begin
                        leading_power_next = mu_result;
                        pw_red_next        = mu_result;
                        setup_valid_next   = 1'b1;
                        window_hash_next   = '0;
                        bytes_seen_next    = '0;
                        p_cache_next       = p_eff;
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_RED_H: begin
                mu_bit   = window_hash_reg[bit_cnt_reg];
                acc_next = mu_result;
                if (bit_last) begin
                    window_hash_next = mu_result;
                    acc_next         = '0;
                    bit_cnt_next     = 5'(HASH_W - 1);
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_RED_T: begin
                mu_bit   = target_hash_reg[bit_cnt_reg];
                acc_next = mu_result;
                if (bit_last) begin
                    tgt_red_next = mu_result;
                    acc_next     = '0;
                    bit_cnt_next = 5'(HASH_W - 1);
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_RED_P: begin
                mu_bit   = leading_power_reg[bit_cnt_reg];
                acc_next = mu_result;
                if (bit_last) begin
                    pw_red_next  = mu_result;
                    p_cache_next = p_eff;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_DBL: begin
                // Double-and-add of the outgoing byte times the leading power.
                acc_next = mu_result;
                if (!rd_byte[bit_cnt_reg[2:0]] && !bit_last) begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_ADD: begin
                mu_op    = MOP_ADD;
                acc_next = mu_result;
                if (!bit_last) begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_NEG: begin
                mu_op    = MOP_NEG;
                acc_next = mu_result;
            end
            ST_SUB: begin
                mu_op        = MOP_ADD;
                mu_addend    = window_hash_reg;
                acc_next     = mu_result;
                bit_cnt_next = 5'd7;
            end
            ST_SHIFT: begin
                mu_bit   = byte_reg[bit_cnt_reg[2:0]];
                acc_next = mu_result;
                if (bit_last) begin
                    window_hash_next = mu_result;
                    win_shift        = 1'b1;
                    if (bytes_seen_reg != '1) begin
                        bytes_seen_next = bytes_seen_reg + INDEX_WIDTH'(1);
                    end
                end else begin
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                end
            end
            ST_CHECK: begin
                found_next    = 1'b0;
                byte_cnt_next = '0;
            end
            ST_CMP: begin
                if (rd_byte != pat_byte) begin
                    found_next = 1'b0;
                end else if (byte_last) begin
                    found_next = 1'b1;
                end else begin
                    byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.match_found = found_reg;
                    m_data_next.match_index = found_reg ? start_idx : '0;
                    m_data_next.text_done   = last_reg;
                    if (last_reg) begin
                        setup_valid_next = 1'b0;
                        bytes_seen_next  = '0;
                        window_hash_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            setup_valid_reg <= 1'b0;
            bytes_seen_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            setup_valid_reg <= setup_valid_next;
            bytes_seen_reg  <= bytes_seen_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_hash_reg   <= window_hash_next;
        target_hash_reg   <= target_hash_next;
        leading_power_reg <= leading_power_next;
        tgt_red_reg       <= tgt_red_next;
        pw_red_reg        <= pw_red_next;
        p_cache_reg       <= p_cache_next;
        acc_reg           <= acc_next;
        bit_cnt_reg       <= bit_cnt_next;
        byte_cnt_reg      <= byte_cnt_next;
        byte_reg          <= byte_next;
        last_reg          <= last_next;
        found_reg         <= found_next;
        m_data_reg        <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/rhpm_mod_unit.sv
// Shared modular step: one shift, add or negate followed by one conditional subtract of the modulus.
module rhpm_mod_unit
    import rhpm_pkg::*;
(
    input  mod_op_t           op,
    input  logic [HASH_W-1:0] acc,
    input  logic              shift_bit,
    input  logic [HASH_W-1:0] addend,
    input  logic [HASH_W-1:0] modulus,
    output logic [HASH_W-1:0] result
);

    logic [HASH_W:0]   pre;
    logic [HASH_W+1:0] diff;

    // Every operation keeps its pre-value below twice the modulus.
    always_comb begin
        case (op)
            MOP_SHIFT: pre = {acc, shift_bit};
            MOP_ADD:   pre = {1'b0, acc} + {1'b0, addend};
            MOP_NEG:   pre = {1'b0, modulus} - {1'b0, acc};
            default:   pre = {1'b0, acc};
        endcase
    end

    assign diff   = {1'b0, pre} - {2'b00, modulus};
    assign result = diff[HASH_W+1] ? pre[HASH_W-1:0] : diff[HASH_W-1:0];

endmodule

FILE: hw/rtl/rhpm_window.sv
// Text window: shift line of the latest bytes with one selectable read tap.
module rhpm_window
    import rhpm_pkg::*;
#(
    parameter int MAX_PATTERN = RHPM_MAX_PATTERN,
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [7:0]       shift_byte,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_byte
);

    logic [7:0] win_reg [MAX_PATTERN];

    // Newest byte enters at entry 0.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg[0] <= shift_byte;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    assign rd_byte = win_reg[rd_idx];

endmodule

FILE: hw/rtl/rhpm_checker.sv
// Port-level assertions for the rolling hash pattern matcher, with its bind.
module rhpm_checker
    import rhpm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Reset leaves no result beat pending.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One byte is worked on at a time, so the input closes after each beat.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // A result never appears in the cycle right after a byte is taken.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result beat too soon after input beat");

    // Without a match the start index reads as zero.
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.match_found |-> m_data.match_index == '0)
        else $error("nonzero index without a match");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_rhpm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
